[hdl/atam_pkg.sv]
package atam_pkg;

    localparam int NUM_TABLES = 6;
    localparam logic [7:0] END_MARK = 8'h24;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_CHECK  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    localparam logic [1:0] SVC_NONE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

[hdl/atam_rule_cmp.sv]
module atam_rule_cmp #(
    parameter int TEXT_BYTES = 16
) (
    input  logic [(TEXT_BYTES-1)*8-1:0] i_rule_bytes,
    input  logic [3:0]                  i_rule_len,
    input  logic [(TEXT_BYTES-1)*8-1:0] i_addr_bytes,
    input  logic [3:0]                  i_addr_len,
    output logic                        o_match
);
    import atam_pkg::*;

    localparam int MAXC = TEXT_BYTES - 1;

    logic [MAXC-1:0] eq;
    logic [7:0]      last_byte;
    logic            ends_mark;
    logic            prefix_ok;
    logic            exact_ok;
    logic [3:0]      len_m1;

    always_comb begin
        len_m1    = i_rule_len - 4'd1;
        last_byte = '0;
        prefix_ok = 1'b1;
        exact_ok  = 1'b1;
        for (int i = 0; i < MAXC; i++) begin
            eq[i] = (i_rule_bytes[8*i +: 8] == i_addr_bytes[8*i +: 8]);
            if (len_m1 == 4'(i)) begin
                last_byte = i_rule_bytes[8*i +: 8];
            end
            if ((4'(i) < i_rule_len) && !eq[i]) begin
                prefix_ok = 1'b0;
            end
            if ((4'(i) < len_m1) && !eq[i]) begin
                exact_ok = 1'b0;
            end
        end
        ends_mark = (last_byte == END_MARK);
        if (i_rule_len == 4'd0) begin
            o_match = 1'b1;
        end else if (ends_mark) begin
            o_match = (i_rule_len == 4'd1) || ((i_addr_len == len_m1) && exact_ok);
        end else begin
            o_match = (i_addr_len >= i_rule_len) && prefix_ok;
        end
    end

endmodule

[hdl/address_text_acl_matcher_unit.sv]
// Address text ACL matcher. Six ordered rule tables (allow and deny for each of three
// services) live in one synchronous memory; each item gives exactly one result item.
// An append or a clear goes from the execute state straight to the done state. A check
// scans the allow rules, then the deny rules of its service, through the single memory
// read port that fetches one rule per cycle; it stops at the first match. Clearing
// resets the per-table fill counts only, so there is no clearing pass. A new item is
// accepted while the previous result still waits in the output register.
module address_text_acl_matcher_unit #(
    parameter int RULES_PER_TABLE = 16,
    parameter int TEXT_BYTES      = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] text_low, [119:64] text_high, [123:120] text_len, [127:124] zero
    input  logic [127:0] s_axis_tdata,
    // [1:0] func, [3:2] service, [4] to_deny
    input  logic [4:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] verdict, [1] table_full, [7:2] zero
    output logic [7:0]   m_axis_tdata
);
    import atam_pkg::*;

    localparam int MAXC  = TEXT_BYTES - 1;
    localparam int RBW   = MAXC * 8;
    localparam int MW    = RBW + 4;
    localparam int DEPTH = NUM_TABLES * RULES_PER_TABLE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(RULES_PER_TABLE + 1);

    t_state           r_state, n_state;
    logic [1:0]       r_func;
    logic [1:0]       r_svc;
    logic             r_deny;
    logic [RBW-1:0]   r_buf;
    logic [3:0]       r_len;
    logic [CW-1:0]    r_count [NUM_TABLES];
    logic [CW-1:0]    n_count [NUM_TABLES];
    logic             r_phase, n_phase;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_rv, n_rv;
    logic             r_rv_phase;
    logic             r_res_verdict, n_res_verdict;
    logic             r_res_full, n_res_full;
    logic             r_out_valid;
    logic             r_out_verdict;
    logic             r_out_full;
    logic             load_out;

    logic [MW-1:0]    r_mem [DEPTH];
    logic [MW-1:0]    r_rd_data;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [2:0]       app_t, scan_t;
    logic             hit;

    logic [3:0]       in_len;
    logic [3:0]       eff_len;
    logic [RBW-1:0]   in_buf;
    logic             zero_seen;
    logic             in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Effective text: clipped length, cut at the first zero byte, tail zeroed
    always_comb begin
        in_len    = (s_axis_tdata[123:120] > 4'(MAXC)) ? 4'(MAXC) : s_axis_tdata[123:120];
        eff_len   = in_len;
        zero_seen = 1'b0;
        for (int i = 0; i < MAXC; i++) begin
            if (!zero_seen && (4'(i) < in_len) && (s_axis_tdata[8*i +: 8] == 8'd0)) begin
                eff_len   = 4'(i);
                zero_seen = 1'b1;
            end
        end
        for (int i = 0; i < MAXC; i++) begin
            in_buf[8*i +: 8] = (4'(i) < eff_len) ? s_axis_tdata[8*i +: 8] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= s_axis_tuser[1:0];
            r_svc  <= s_axis_tuser[3:2];
            r_deny <= s_axis_tuser[4];
            r_buf  <= in_buf;
            r_len  <= eff_len;
        end
    end

    assign app_t     = {r_svc, r_deny};
    assign scan_t    = {r_svc, r_phase};
    assign mem_waddr = AW'(app_t) * AW'(RULES_PER_TABLE) + AW'(r_count[app_t]);
    assign mem_raddr = AW'(scan_t) * AW'(RULES_PER_TABLE) + AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= {r_len, r_buf};
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    atam_rule_cmp #(
        .TEXT_BYTES (TEXT_BYTES)
    ) u_cmp (
        .i_rule_bytes (r_rd_data[RBW-1:0]),
        .i_rule_len   (r_rd_data[RBW +: 4]),
        .i_addr_bytes (r_buf),
        .i_addr_len   (r_len),
        .o_match      (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_count[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rv    <= n_rv;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase       <= n_phase;
        r_idx         <= n_idx;
        r_rv_phase    <= r_phase;
        r_res_verdict <= n_res_verdict;
        r_res_full    <= n_res_full;
    end

    always_comb begin
        logic issue;
        logic exhausted;
        issue         = 1'b0;
        exhausted     = 1'b0;
        n_state       = r_state;
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_rv          = 1'b0;
        n_res_verdict = r_res_verdict;
        n_res_full    = r_res_full;
        n_count       = r_count;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_verdict = 1'b0;
                n_res_full    = 1'b0;
                n_phase       = 1'b0;
                n_idx         = '0;
                n_state       = S_DONE;
                case (t_func'(r_func))
                    FUNC_APPEND: begin
                        if (r_svc != SVC_NONE) begin
                            if (r_count[app_t] >= CW'(RULES_PER_TABLE)) begin
                                n_res_full = 1'b1;
                            end else begin
                                mem_we         = 1'b1;
                                n_count[app_t] = r_count[app_t] + CW'(1);
                            end
                        end
                    end
                    FUNC_CHECK: begin
                        if (r_svc != SVC_NONE) begin
                            n_state = S_SCAN;
                        end
                    end
                    FUNC_CLEAR: begin
                        for (int t = 0; t < NUM_TABLES; t++) begin
                            n_count[t] = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (r_idx < r_count[scan_t]) begin
                    mem_re = 1'b1;
                    issue  = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                    n_idx   = '0;
                end else begin
                    exhausted = 1'b1;
                end
                // reads return in order: allow rules before deny rules
                if (r_rv && hit) begin
                    n_res_verdict = r_rv_phase;
                    n_state       = S_DONE;
                end else if (exhausted) begin
                    n_res_verdict = 1'b0;
                    n_state       = S_DONE;
                end
                n_rv = issue && (n_state == S_SCAN);
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_verdict <= r_res_verdict;
            r_out_full    <= r_res_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_full, r_out_verdict};

    logic count_ok;
    always_comb begin
        count_ok = 1'b1;
        for (int t = 0; t < NUM_TABLES; t++) begin
            if (r_count[t] > CW'(RULES_PER_TABLE)) begin
                count_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_ok)
        else $error("rule count above table size");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> (r_state == S_SCAN))
        else $error("rule read pending outside scan");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

    a_exclusive_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out_verdict && r_out_full))
        else $error("deny and full flagged together");

endmodule

[bench/address_text_acl_matcher_unit_tb.sv]
module address_text_acl_matcher_unit_tb;
    import atam_pkg::*;

    localparam int RULES          = 16;
    localparam int ITEM_TARGET    = 1550;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [63:0] ALPHABET = "012.ab:9";

    typedef struct packed {
        t_func        func;
        logic [1:0]   service;
        logic         to_deny;
        logic [119:0] text;
        logic [3:0]   text_len;
    } acl_req_t;

    typedef struct packed {
        logic verdict;
        logic table_full;
    } acl_resp_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [63:0] text_low, [119:64] text_high, [123:120] text_len, [127:124] zero
    logic [127:0] s_axis_tdata = '0;
    // [1:0] func, [3:2] service, [4] to_deny
    logic [4:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] verdict, [1] table_full, [7:2] zero
    logic [7:0]   m_axis_tdata;

    address_text_acl_matcher_unit #(
        .RULES_PER_TABLE(RULES),
        .TEXT_BYTES     (16)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow of the rule tables
    logic [119:0] acl_text [0:NUM_TABLES*RULES-1];
    logic [3:0]   acl_len  [0:NUM_TABLES*RULES-1];
    int           acl_cnt  [0:NUM_TABLES-1];

    acl_req_t  pending_q[$];
    acl_resp_t answer_q[$];
    acl_req_t  item_now;
    int        items_total = 0;
    int        items_in = 0;
    int        mismatches = 0;

    function automatic int eff_len(logic [119:0] t, logic [3:0] n);
        int k;
        int len;
        len = 0;
        for (k = 0; k < 15; k++)
            if (len == k && k < n && t[8*k +: 8] != 8'h00) len = k + 1;
        return len;
    endfunction

    function automatic logic [119:0] keep_bytes(logic [119:0] t, int len);
        logic [119:0] r;
        int k;
        r = '0;
        for (k = 0; k < len; k++) r[8*k +: 8] = t[8*k +: 8];
        return r;
    endfunction

    function automatic logic rule_hit(int idx, logic [119:0] addr, int alen);
        logic [119:0] rt;
        int rlen;
        int cmp;
        int k;
        logic hit;
        rt = acl_text[idx];
        rlen = int'(acl_len[idx]);
        if (rlen == 0) return 1'b1;
        if (rt[8*(rlen-1) +: 8] != END_MARK) begin
            if (alen < rlen) return 1'b0;
            cmp = rlen;
        end else begin
            if (rlen == 1) return 1'b1;
            if (alen != rlen - 1) return 1'b0;
            cmp = rlen - 1;
        end
        hit = 1'b1;
        for (k = 0; k < cmp; k++)
            if (rt[8*k +: 8] != addr[8*k +: 8]) hit = 1'b0;
        return hit;
    endfunction

    function automatic logic table_hit(int t, logic [119:0] addr, int alen);
        int e;
        logic hit;
        hit = 1'b0;
        for (e = 0; e < acl_cnt[t]; e++)
            if (rule_hit(t * RULES + e, addr, alen)) hit = 1'b1;
        return hit;
    endfunction

    function automatic acl_resp_t acl_answer(acl_req_t q);
        acl_resp_t r;
        int len;
        int t;
        int idx;
        logic [119:0] txt;
        r = '0;
        len = eff_len(q.text, q.text_len);
        txt = keep_bytes(q.text, len);
        case (q.func)
            FUNC_APPEND: begin
                if (q.service != SVC_NONE) begin
                    t = q.service * 2 + q.to_deny;
                    if (acl_cnt[t] >= RULES) begin
                        r.table_full = 1'b1;
                    end else begin
                        idx = t * RULES + acl_cnt[t];
                        acl_text[idx] = txt;
                        acl_len[idx] = 4'(len);
                        acl_cnt[t] = acl_cnt[t] + 1;
                    end
                end
            end
            FUNC_CHECK: begin
                if (q.service != SVC_NONE) begin
                    if (table_hit(q.service * 2, txt, len)) r.verdict = 1'b0;
                    else if (table_hit(q.service * 2 + 1, txt, len)) r.verdict = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                for (t = 0; t < NUM_TABLES; t++) acl_cnt[t] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic acl_req_t mk_req(t_func f, logic [1:0] s, logic d,
                                        logic [119:0] t, logic [3:0] n);
        acl_req_t q;
        q.func = f;
        q.service = s;
        q.to_deny = d;
        q.text = t;
        q.text_len = n;
        return q;
    endfunction

    function automatic logic [119:0] str_text(string s);
        logic [119:0] r;
        int k;
        r = '0;
        for (k = 0; k < s.len() && k < 15; k++) r[8*k +: 8] = s[k];
        return r;
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return ALPHABET[8*$urandom_range(0, 7) +: 8];
        if (r < 80) return END_MARK;
        if (r < 97) return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic make_rule(output logic [119:0] t, output logic [3:0] n);
        int len;
        int k;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
        t = ($urandom_range(0, 1) == 0) ? '0 : 120'({$urandom, $urandom, $urandom, $urandom});
        for (k = 0; k < len; k++) t[8*k +: 8] = rand_char();
        if (len > 0 && $urandom_range(0, 3) == 0) t[8*(len-1) +: 8] = END_MARK;
        n = 4'(len);
    endtask

    // driver
    int tx_gap = 0;
    int tx_calm = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                answer_q.push_back(acl_answer(item_now));
                items_in++;
            end
            if (tx_calm > 0) tx_calm--;
            else if ($urandom_range(0, 299) == 0) tx_calm = $urandom_range(40, 200);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    item_now = pending_q.pop_front();
                    s_axis_tdata <= {4'b0, item_now.text_len, item_now.text};
                    s_axis_tuser <= {item_now.to_deny, item_now.service, item_now.func};
                    s_axis_tvalid <= 1'b1;
                    tx_gap = (tx_calm > 0) ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int        rx_stall = 0;
    int        rx_calm = 0;
    int        rx_hold = 0;
    int        results_seen = 0;
    logic      hold_done = 1'b0;
    acl_resp_t want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: tdata %h", m_axis_tdata);
                end else begin
                    want = answer_q.pop_front();
                    if (m_axis_tdata[0] !== want.verdict || m_axis_tdata[1] !== want.table_full) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: expected verdict %0b full %0b, got verdict %0b full %0b",
                                     results_seen, want.verdict, want.table_full,
                                     m_axis_tdata[0], m_axis_tdata[1]);
                    end
                end
                results_seen++;
            end
            if (results_seen == 200 && !hold_done) begin
                hold_done = 1'b1;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_calm > 0) rx_calm--;
            else if ($urandom_range(0, 299) == 0) rx_calm = $urandom_range(40, 200);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_stall = (rx_calm > 0) ? 0 : pick_gap();
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL address_text_acl_matcher_unit");
            $finish;
        end
    end

    initial begin
        acl_req_t     pool[$];
        acl_req_t     p;
        logic [119:0] t;
        logic [119:0] a;
        logic [3:0]   n;
        int           useful;
        int           focus;
        int           tbl;
        int           na;
        int           nc;
        int           k;
        int           j;
        int           m;
        int           len;
        int           alen;
        int           svc;

        for (k = 0; k < NUM_TABLES; k++) acl_cnt[k] = 0;

        // directed part
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd0, 1'b0, '0, 4'd0));
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd0, 1'b0, str_text("10.0."), 4'd5));
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd0, 1'b1, '1, 4'd0));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd0, 1'b0, str_text("10.0.0.1"), 4'd8));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd0, 1'b0, str_text("192.1"), 4'd5));
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd1, 1'b1, str_text("$"), 4'd1));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd1, 1'b0, str_text("x"), 4'd1));
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd2, 1'b0, str_text("abc$"), 4'd4));
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd2, 1'b1, str_text("ab"), 4'd2));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd2, 1'b0, str_text("abc"), 4'd3));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd2, 1'b1, str_text("abcd"), 4'd4));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd2, 1'b0, str_text("a"), 4'd1));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd2, 1'b0, str_text("abc$"), 4'd4));
        pending_q.push_back(mk_req(FUNC_APPEND, SVC_NONE, 1'b1, str_text("zz"), 4'd2));
        pending_q.push_back(mk_req(FUNC_CHECK, SVC_NONE, 1'b0, str_text("zz"), 4'd2));
        pending_q.push_back(mk_req(FUNC_NOP, SVC_NONE, 1'b1, '1, 4'hf));
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd0, 1'b0, '1, 4'hf));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd0, 1'b1, '1, 4'hf));
        t = str_text("xy?zz");
        t[23:16] = 8'h00;
        pending_q.push_back(mk_req(FUNC_APPEND, 2'd1, 1'b0, t, 4'd5));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd1, 1'b0, str_text("xyq"), 4'd3));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd1, 1'b0, '1, 4'd0));
        pending_q.push_back(mk_req(FUNC_CLEAR, 2'd0, 1'b0, '0, 4'd0));
        pending_q.push_back(mk_req(FUNC_CHECK, 2'd1, 1'b0, str_text("xyq"), 4'd3));

        // random part: fill tables, then probe, mostly with addresses from the rules
        useful = 0;
        while (useful < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) begin
                pending_q.push_back(mk_req(FUNC_CLEAR, 2'($urandom), 1'($urandom),
                                           120'({$urandom, $urandom, $urandom, $urandom}),
                                           4'($urandom)));
                pool.delete();
                useful++;
            end
            focus = $urandom_range(0, NUM_TABLES - 1);
            na = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 8);
            for (k = 0; k < na; k++) begin
                tbl = ($urandom_range(0, 3) != 0) ? focus : $urandom_range(0, NUM_TABLES - 1);
                make_rule(t, n);
                p = mk_req(FUNC_APPEND, 2'(tbl / 2), 1'(tbl % 2), t, n);
                pending_q.push_back(p);
                pool.push_back(p);
                if (pool.size() > 48) void'(pool.pop_front());
                useful++;
            end
            nc = $urandom_range(3, 16);
            for (k = 0; k < nc; k++) begin
                svc = ($urandom_range(0, 4) != 0) ? focus / 2 : $urandom_range(0, 2);
                if (pool.size() > 0 && $urandom_range(0, 4) != 0) begin
                    p = pool[$urandom_range(0, pool.size() - 1)];
                    len = eff_len(p.text, p.text_len);
                    a = keep_bytes(p.text, len);
                    alen = len;
                    case ($urandom_range(0, 3))
                        0: begin
                            if (len > 1 && a[8*(len-1) +: 8] == END_MARK) begin
                                a[8*(len-1) +: 8] = 8'h00;
                                alen = len - 1;
                            end
                        end
                        1: begin
                            m = $urandom_range(1, 4);
                            for (j = 0; j < m; j++)
                                if (alen < 15) begin
                                    a[8*alen +: 8] = ALPHABET[8*$urandom_range(0, 7) +: 8];
                                    alen++;
                                end
                        end
                        2: begin
                            if (alen > 0) a[8*$urandom_range(0, alen - 1) +: 8] = rand_char();
                        end
                        default: begin
                            if (alen > 0) alen--;
                        end
                    endcase
                    // zero byte after the text ends it even with a longer length
                    if (alen < 15 && $urandom_range(0, 7) == 0) begin
                        a[8*alen +: 8] = 8'h00;
                        alen = 15;
                    end
                    n = 4'(alen);
                end else begin
                    make_rule(a, n);
                end
                pending_q.push_back(mk_req(FUNC_CHECK, 2'(svc), 1'($urandom), a, n));
                useful++;
            end
            if ($urandom_range(0, 3) == 0) begin
                make_rule(t, n);
                if ($urandom_range(0, 1) == 0)
                    pending_q.push_back(mk_req(FUNC_NOP, 2'($urandom), 1'($urandom), t, n));
                else
                    pending_q.push_back(mk_req(t_func'($urandom_range(0, 3)), SVC_NONE,
                                               1'($urandom), t, n));
            end
        end
        items_total = pending_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_in < items_total || answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS address_text_acl_matcher_unit");
        else
            $display("FAIL address_text_acl_matcher_unit");
        $finish;
    end

endmodule
